FILE: rtl/dshot_pkg.sv
// Package for the DShot frame transmitter: item types, register indexes,
// reset values and the frame builder. No dependencies.
`timescale 1ns / 1ps

package dshot_pkg;

    localparam int DATA_BITS = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILING_BITS = 2'd3;

    localparam logic [7:0] RST_PERIOD_TOP    = 8'd20;
    localparam logic [7:0] RST_ZERO_HIGH     = 8'd7;
    localparam logic [7:0] RST_ONE_HIGH      = 8'd14;
    localparam logic [2:0] RST_TRAILING_BITS = 3'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [10:0] throttle;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } t_out_item;

    // Frame is the throttle with the telemetry bit at 0, then the XOR of its nibbles.
    function automatic logic [DATA_BITS-1:0] make_frame(input logic [10:0] throttle);
        logic [11:0] v;
        logic [3:0]  ck;
        v  = {throttle, 1'b0};
        ck = v[3:0] ^ v[7:4] ^ v[11:8];
        return {v, ck};
    endfunction

endpackage

FILE: rtl/dshot_core.sv
// DShot transmitter state: configuration registers, frame, slot and tick
// counters, and the result of the item being transferred. Uses dshot_pkg.
`timescale 1ns / 1ps

module dshot_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dshot_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dshot_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_item_valid,
    input  dshot_pkg::t_in_item                 i_item,
    output dshot_pkg::t_out_item                o_res
);

    logic [7:0] r_period_top;
    logic [7:0] r_zero_high;
    logic [7:0] r_one_high;
    logic [2:0] r_trailing;

    logic                           r_sending, n_sending;
    logic [dshot_pkg::DATA_BITS-1:0] r_frame, n_frame;
    logic [4:0]                     r_slot, n_slot;
    logic [7:0]                     r_tick, n_tick;

    logic [4:0] slot_inc;
    logic [4:0] slot_limit;
    logic [3:0] bit_pos;
    logic [7:0] duty;
    logic       accepted;
    logic       done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_top <= dshot_pkg::RST_PERIOD_TOP;
            r_zero_high  <= dshot_pkg::RST_ZERO_HIGH;
            r_one_high   <= dshot_pkg::RST_ONE_HIGH;
            r_trailing   <= dshot_pkg::RST_TRAILING_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dshot_pkg::CFG_PERIOD_TOP:    r_period_top <= i_cfg_data;
                dshot_pkg::CFG_ZERO_HIGH:     r_zero_high  <= i_cfg_data;
                dshot_pkg::CFG_ONE_HIGH:      r_one_high   <= i_cfg_data;
                dshot_pkg::CFG_TRAILING_BITS: r_trailing   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign slot_inc   = r_slot + 5'd1;
    assign slot_limit = 5'(dshot_pkg::DATA_BITS) + {2'b00, r_trailing};

    always_comb begin
        n_sending = r_sending;
        n_frame   = r_frame;
        n_slot    = r_slot;
        n_tick    = r_tick;
        accepted  = 1'b0;
        done      = 1'b0;
        if (i_item.cmd == dshot_pkg::CMD_WRITE) begin
            // A write that arrives mid-frame is dropped.
            if (!r_sending) begin
                n_frame   = dshot_pkg::make_frame(i_item.throttle);
                n_sending = 1'b1;
                n_slot    = '0;
                n_tick    = '0;
                accepted  = 1'b1;
            end
        end else if (r_sending) begin
            if (r_tick >= r_period_top) begin
                n_tick = '0;
                if (slot_inc >= slot_limit) begin
                    n_sending = 1'b0;
                    n_slot    = '0;
                    done      = 1'b1;
                end else begin
                    n_slot = slot_inc;
                end
            end else begin
                n_tick = r_tick + 8'd1;
            end
        end
    end

    // Level of the line after this item, from the updated state.
    assign bit_pos = 4'(dshot_pkg::DATA_BITS - 1) - n_slot[3:0];

    always_comb begin
        if (n_slot >= 5'(dshot_pkg::DATA_BITS)) begin
            duty = '0;
        end else if (n_frame[bit_pos]) begin
            duty = r_one_high;
        end else begin
            duty = r_zero_high;
        end
    end

    assign o_res.pin_level  = n_sending && (n_tick < duty);
    assign o_res.busy_res   = n_sending;
    assign o_res.accepted   = accepted;
    assign o_res.frame_done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_frame   <= '0;
            r_slot    <= '0;
            r_tick    <= '0;
        end else if (i_item_valid) begin
            r_sending <= n_sending;
            r_frame   <= n_frame;
            r_slot    <= n_slot;
            r_tick    <= n_tick;
        end
    end

    a_idle_counters_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_slot == 5'd0 && r_tick == 8'd0))
        else $error("counters not cleared while idle");

    a_start_loads_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_res.accepted) |=> (r_sending && r_slot == 5'd0))
        else $error("accepted write did not start a frame");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.frame_done |-> (!o_res.busy_res && !o_res.pin_level && !o_res.accepted))
        else $error("frame end result inconsistent");

endmodule

FILE: rtl/dshot_skid.sv
// Two-entry output buffer for result items: an output register plus a skid
// register, so a new transfer is taken while a result waits. Uses dshot_pkg.
`timescale 1ns / 1ps

module dshot_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dshot_pkg::t_out_item i_data,
    output logic                 o_space,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dshot_pkg::t_out_item o_out_data
);

    logic                 r_out_valid;
    dshot_pkg::t_out_item r_out_data;
    logic                 r_skid_valid;
    dshot_pkg::t_out_item r_skid_data;
    logic                 pop;

    assign pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end
        if (i_push && r_out_valid && !pop) begin
            r_skid_data <= i_data;
        end
    end

    // The skid register only fills when the input side cannot be refused.
    assign o_space     = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !r_skid_valid && i_push) |=> r_skid_valid)
        else $error("stalled result lost the incoming transfer");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("waiting result changed before its transfer");

endmodule

FILE: rtl/dshot_frame_transmitter.sv
// Top level of the DShot frame transmitter. Instantiates dshot_core and
// dshot_skid; uses dshot_pkg for item types and register indexes.
//
// Usage: each input transfer carries cmd and throttle. A write (cmd 1)
// starts a 16-bit frame if no frame is in flight, otherwise it is dropped
// and its result shows accepted 0. A tick (cmd 0) advances the bit timer
// by one count. Every input transfer produces exactly one result transfer
// with pin_level, busy_res, accepted and frame_done.
// The result of an accepted transfer is registered in the output register,
// or in the skid register while the output stalls. One item is taken
// every cycle while the output side keeps up; the state update is a single
// combinational pass from the state registers to the result register.
// When the receiver stalls, the output register holds its result and a
// skid register takes one more transfer; o_in_ready then falls until the
// receiver drains a result.
// Reset (i_rst_n low, synchronous) restores the register defaults (period
// 20, zero duty 7, one duty 14, two trailing slots), clears the frame state
// and empties the output buffer. Configuration writes on i_cfg_we take
// effect at the next edge and are meant to be issued while idle.
`timescale 1ns / 1ps

module dshot_frame_transmitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dshot_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dshot_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dshot_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dshot_pkg::t_out_item                o_out_item
);

    logic                 in_xfer;
    logic                 space;
    dshot_pkg::t_out_item res;

    assign o_in_ready = space;
    assign in_xfer    = i_in_valid && space;

    dshot_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (in_xfer),
        .i_item       (i_in_item),
        .o_res        (res)
    );

    dshot_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_data      (res),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_item)
    );

endmodule
